[hdl/mec_pkg.sv]
// ============================================================================
// mec_pkg - shared types and constants for the escape-time colorizer
// Number formats, channel coefficients and controller state encodings.
// ============================================================================
package mec_pkg;

    // Default parameter values
    localparam int MAX_ITER_DEF  = 1000;
    localparam int FRAC_BITS_DEF = 28;
    localparam int Q_DEPTH_DEF   = 2;

    // Fixed widths
    localparam int IN_W    = 32;   // input point parts, Q4.28
    localparam int IN_FRAC = 28;
    localparam int Z_W     = 64;   // internal z and c
    localparam int HALF_W  = 32;   // multiplier operand width
    localparam int PROD_W  = 128;  // full square / cross product
    localparam int CNT_W   = 10;   // escape_count port
    localparam int COL_W   = 8;    // one color channel
    localparam int GAIN_W  = 13;   // widest channel gain (4335)

    // Color channel selector
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Iteration controller states
    typedef enum logic [2:0] {
        IT_IDLE,
        IT_CHECK,
        IT_MUL,
        IT_SUM,
        IT_UPD,
        IT_PUSH
    } t_iter_st;

    // Shading controller states
    typedef enum logic [1:0] {
        SH_IDLE,
        SH_MUL,
        SH_DIV,
        SH_OUT
    } t_shd_st;

    // Gain of each channel: 255 times its polynomial weight (blue carries x2)
    function automatic logic [GAIN_W-1:0] chan_gain(input t_chan ch);
        case (ch)
            CH_RED:   chan_gain = GAIN_W'(2295);
            CH_GREEN: chan_gain = GAIN_W'(3825);
            CH_BLUE:  chan_gain = GAIN_W'(4335);
            default:  chan_gain = '0;
        endcase
    endfunction

    // Power of (M - n) in the channel polynomial; n takes the rest of four
    function automatic logic [1:0] chan_pow(input t_chan ch);
        case (ch)
            CH_RED:   chan_pow = 2'd1;
            CH_GREEN: chan_pow = 2'd2;
            CH_BLUE:  chan_pow = 2'd3;
            default:  chan_pow = 2'd0;
        endcase
    endfunction

    // Blue divides by twice M^4 to undo the doubled gain
    function automatic logic chan_half(input t_chan ch);
        case (ch)
            CH_BLUE: chan_half = 1'b1;
            default: chan_half = 1'b0;
        endcase
    endfunction

endpackage

[hdl/mec_ifs.sv]
// ============================================================================
// mec_ifs - stream channels of the escape-time colorizer
// Point channel (c in Q4.28) and color channel (count plus RGB).
// ============================================================================
interface mec_point_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       c_real;
    logic signed [31:0]       c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mec_color_if;
    logic       valid;
    logic       ready;
    logic [9:0] escape_count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output escape_count, output red, output green,
                    output blue, input ready);
    modport sink   (input valid, input escape_count, input red, input green,
                    input blue, output ready);
endinterface

[hdl/mec_iter.sv]
// ============================================================================
// mec_iter - escape-time iteration engine
// Runs z = z*z + c on one point with three 32x32 multipliers, four partial
// products per square, and hands the escape count to the job queue.
// ============================================================================
module mec_iter
    import mec_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW       = $clog2(MAX_ITER + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mec_point_if.sink       i_point,
    output logic            o_push_valid,
    output logic [CW-1:0]   o_push_count,
    input  logic            i_push_ready
);

    localparam int SHL = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int SHR = (FRAC_BITS <  IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;
    localparam logic [Z_W-1:0]    LIM   = Z_W'(1) << (FRAC_BITS + 1);
    localparam logic [PROD_W-1:0] BOUND = PROD_W'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [Z_W-1:0] ZMAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] ZMIN = {1'b1, {(Z_W-1){1'b0}}};

    t_iter_st r_state, n_state;

    logic signed [Z_W-1:0]    r_cr, r_ci, r_zr, r_zi;
    logic [Z_W-1:0]           r_a, r_b;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_aa, r_bb, r_ab;
    logic signed [PROD_W-1:0] r_diff, r_xy;
    logic [1:0]               r_step;
    logic [CW-1:0]            r_n;

    // Q4.28 to internal format: exact left shift or floor right shift
    function automatic logic signed [Z_W-1:0] load_c(input logic signed [IN_W-1:0] v);
        logic signed [Z_W-1:0] s;
        s = Z_W'(v);
        load_c = (s <<< SHL) >>> SHR;
    endfunction

    function automatic logic [Z_W-1:0] mag(input logic signed [Z_W-1:0] v);
        mag = v[Z_W-1] ? Z_W'(-v) : Z_W'(v);
    endfunction

    // Signed add clamped to the 64-bit range
    function automatic logic signed [Z_W-1:0] sat_add(input logic signed [Z_W-1:0] x,
                                                      input logic signed [Z_W-1:0] y);
        logic signed [Z_W:0] s;
        s = (Z_W+1)'(x) + (Z_W+1)'(y);
        if (s[Z_W] != s[Z_W-1]) begin
            sat_add = s[Z_W] ? ZMIN : ZMAX;
        end else begin
            sat_add = s[Z_W-1:0];
        end
    endfunction

    // Place one 64-bit partial product by its half indexes
    function automatic logic [PROD_W-1:0] place(input logic [2*HALF_W-1:0] pp,
                                                input logic [1:0] step);
        case (step)
            2'd0:    place = PROD_W'(pp);
            2'd1,
            2'd2:    place = PROD_W'(pp) << HALF_W;
            2'd3:    place = PROD_W'(pp) << (2 * HALF_W);
            default: place = '0;
        endcase
    endfunction

    // Escape checks
    logic [Z_W-1:0]    mag_r, mag_i;
    logic              esc_chk, esc_sum;
    logic [PROD_W-1:0] sum_sq;

    assign mag_r   = mag(r_zr);
    assign mag_i   = mag(r_zi);
    assign esc_chk = (r_n >= CW'(MAX_ITER)) || (mag_r > LIM) || (mag_i > LIM);
    assign sum_sq  = r_aa + r_bb;
    assign esc_sum = sum_sq > BOUND;

    // Partial products: step bit 1 picks the high half of x, bit 0 of y
    logic [HALF_W-1:0]   a_x, a_y, b_x, b_y;
    logic [2*HALF_W-1:0] pp_aa, pp_bb, pp_ab;

    assign a_x   = r_step[1] ? r_a[Z_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign a_y   = r_step[0] ? r_a[Z_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_x   = r_step[1] ? r_b[Z_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign b_y   = r_step[0] ? r_b[Z_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign pp_aa = a_x * a_y;
    assign pp_bb = b_x * b_y;
    assign pp_ab = a_x * b_y;

    // Next z from the registered difference and cross product
    logic signed [PROD_W-1:0] re_sh, im_sh;
    assign re_sh = r_diff >>> FRAC_BITS;
    assign im_sh = r_xy >>> FRAC_BITS;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            IT_IDLE:  if (i_point.valid) n_state = IT_CHECK;
            IT_CHECK: n_state = esc_chk ? IT_PUSH : IT_MUL;
            IT_MUL:   if (r_step == 2'd3) n_state = IT_SUM;
            IT_SUM:   n_state = esc_sum ? IT_PUSH : IT_UPD;
            IT_UPD:   n_state = IT_CHECK;
            IT_PUSH:  if (i_push_ready) n_state = IT_IDLE;
            default:  n_state = IT_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_point.ready = (r_state == IT_IDLE);
        o_push_valid  = (r_state == IT_PUSH);
    end
    assign o_push_count = r_n;

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            IT_IDLE: begin
                r_cr <= load_c(i_point.c_real);
                r_ci <= load_c(i_point.c_imag);
                r_zr <= '0;
                r_zi <= '0;
                r_n  <= '0;
            end
            IT_CHECK: begin
                r_a    <= mag_r;
                r_b    <= mag_i;
                r_neg  <= r_zr[Z_W-1] != r_zi[Z_W-1];
                r_aa   <= '0;
                r_bb   <= '0;
                r_ab   <= '0;
                r_step <= '0;
            end
            IT_MUL: begin
                r_aa   <= r_aa + place(pp_aa, r_step);
                r_bb   <= r_bb + place(pp_bb, r_step);
                r_ab   <= r_ab + place(pp_ab, r_step);
                r_step <= r_step + 2'd1;
            end
            IT_SUM: begin
                r_diff <= r_aa - r_bb;
                r_xy   <= r_neg ? -(r_ab << 1) : (r_ab << 1);
            end
            IT_UPD: begin
                r_zr <= sat_add(re_sh[Z_W-1:0], r_cr);
                r_zi <= sat_add(im_sh[Z_W-1:0], r_ci);
                r_n  <= r_n + CW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/mec_fifo.sv]
// ============================================================================
// mec_fifo - short job queue
// Register FIFO between the iteration engine and the shading unit.
// ============================================================================
module mec_fifo
    import mec_pkg::*;
#(
    parameter int W     = 10,
    parameter int DEPTH = Q_DEPTH_DEF,     // two or more
    localparam int PW   = $clog2(DEPTH),
    localparam int LW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  logic [W-1:0]  i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output logic [W-1:0]  o_pop_data,
    input  logic          i_pop_ready,
    output logic [LW-1:0] o_level
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [LW-1:0] r_level;
    logic          push_ok, pop_ok;

    assign o_push_ready = r_level != LW'(DEPTH);
    assign o_pop_valid  = r_level != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign o_level      = r_level;
    assign push_ok      = i_push_valid && o_push_ready;
    assign pop_ok       = o_pop_valid && i_pop_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (push_ok) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (pop_ok)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (push_ok && !pop_ok) begin
                r_level <= r_level + LW'(1);
            end else if (pop_ok && !push_ok) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_push_data;
    end

endmodule

[hdl/mec_shade.sv]
// ============================================================================
// mec_shade - polynomial colorizer
// Forms k*(M-n)^p*n^(4-p) with one narrow multiplier over four steps, then
// divides by M^4, or 2*M^4 for blue, with a reciprocal multiply and one
// compare-and-subtract fix-up, for red, green and blue in turn.
// ============================================================================
module mec_shade
    import mec_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF,
    localparam int CW      = $clog2(MAX_ITER + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  logic [CW-1:0] i_pop_count,
    output logic          o_pop_ready,
    mec_color_if.source   o_color
);

    localparam int NUM_W = GAIN_W + 4 * CW;
    localparam logic [NUM_W-1:0] MW  = NUM_W'(MAX_ITER);
    localparam logic [NUM_W-1:0] M4  = MW * MW * MW * MW;
    localparam logic [NUM_W-1:0] DV1 = M4;          // red, green
    localparam logic [NUM_W-1:0] DV2 = M4 << 1;     // blue

    // Reciprocal divide: the numerator drops SH low bits, the estimate is at
    // most one short and a single compare against the divisor fixes it
    localparam int LG1  = $clog2(DV1 + NUM_W'(1)) - 1;     // floor(log2(DV1))
    localparam int SH   = (LG1 >= 2) ? LG1 - 2 : 0;
    localparam int RT   = NUM_W + 2;
    localparam int PH_W = NUM_W - SH;
    localparam int RC_W = RT - LG1 + 1;
    localparam logic [RT:0] ONE_RT = (RT+1)'(1) << RT;
    localparam logic [RT:0] RCP1   = ONE_RT / (RT+1)'(DV1);
    localparam logic [RT:0] RCP2   = ONE_RT / (RT+1)'(DV2);

    t_shd_st r_state, n_state;

    t_chan             r_ch;
    logic [CW-1:0]     r_n;
    logic [NUM_W-1:0]  r_acc, r_num;
    logic [2:0]        r_k;
    logic [COL_W-1:0]  r_q, r_red, r_green, r_blue;

    logic              r_ov;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [COL_W-1:0]  r_o_red, r_o_green, r_o_blue;

    logic                   in_set, last_mul, last_div, load;
    logic [CW-1:0]          factor;
    logic [NUM_W-1:0]       prod;
    logic [RC_W-1:0]        rcp;
    logic [NUM_W-1:0]       dvs, q_mul, num_left;
    logic [PH_W+RC_W-1:0]   est;
    logic [COL_W-1:0]       q_est, q_fix;
    t_chan                  ch_next;

    assign in_set   = i_pop_count >= CW'(MAX_ITER);
    assign last_mul = r_k == 3'd3;
    assign last_div = r_k == 3'd1;
    assign factor   = (r_k < {1'b0, chan_pow(r_ch)}) ? CW'(MAX_ITER) - r_n : r_n;
    assign prod     = r_acc[NUM_W-CW-1:0] * factor;
    assign load     = (r_state == SH_OUT) && (!r_ov || o_color.ready);

    // Quotient estimate, then one correction step
    assign rcp      = chan_half(r_ch) ? RC_W'(RCP2) : RC_W'(RCP1);
    assign dvs      = chan_half(r_ch) ? DV2 : DV1;
    assign est      = r_num[NUM_W-1:SH] * rcp;
    assign q_est    = COL_W'(est >> (RT - SH));
    assign q_mul    = NUM_W'(r_q) * dvs;
    assign num_left = r_num - q_mul;
    assign q_fix    = r_q + COL_W'(num_left >= dvs);

    always_comb begin
        case (r_ch)
            CH_RED:   ch_next = CH_GREEN;
            CH_GREEN: ch_next = CH_BLUE;
            default:  ch_next = CH_RED;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SH_IDLE: if (i_pop_valid) n_state = in_set ? SH_OUT : SH_MUL;
            SH_MUL:  if (last_mul) n_state = SH_DIV;
            SH_DIV:  if (last_div) n_state = (r_ch == CH_BLUE) ? SH_OUT : SH_MUL;
            SH_OUT:  if (load) n_state = SH_IDLE;
            default: n_state = SH_IDLE;
        endcase
    end

    // Queue handshake
    always_comb begin
        o_pop_ready = (r_state == SH_IDLE);
    end

    // Shading datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            SH_IDLE: begin
                r_n     <= i_pop_count;
                r_ch    <= CH_RED;
                r_acc   <= NUM_W'(chan_gain(CH_RED));
                r_k     <= '0;
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
            SH_MUL: begin
                r_acc <= prod;
                if (last_mul) begin
                    r_k   <= '0;
                    r_num <= prod;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            SH_DIV: begin
                if (last_div) begin
                    case (r_ch)
                        CH_RED:   r_red   <= q_fix;
                        CH_GREEN: r_green <= q_fix;
                        default:  r_blue  <= q_fix;
                    endcase
                    r_ch  <= ch_next;
                    r_acc <= NUM_W'(chan_gain(ch_next));
                    r_k   <= '0;
                end else begin
                    r_q <= q_est;
                    r_k <= r_k + 3'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_color.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_cnt   <= CNT_W'(r_n);
            r_o_red   <= r_red;
            r_o_green <= r_green;
            r_o_blue  <= r_blue;
        end
    end

    assign o_color.valid        = r_ov;
    assign o_color.escape_count = r_o_cnt;
    assign o_color.red          = r_o_red;
    assign o_color.green        = r_o_green;
    assign o_color.blue         = r_o_blue;

endmodule

[hdl/mandelbrot_escape_colorizer.sv]
// ============================================================================
// mandelbrot_escape_colorizer - escape-time iteration with polynomial color
// Iteration engine, job queue and shading unit, each with its own stall.
// ============================================================================
//
//  Channel   Dir  Beat contents                        Handshake
//  i_point   in   c_real, c_imag (signed Q4.28)        valid / ready
//  o_color   out  escape_count, red, green, blue       valid / ready
//
//  One escape iteration runs check, four partial-product steps on three
//  shared 32x32 multipliers, sum/compare and update; a point inside the set
//  runs the most iterations and so occupies the engine longest.
//  Shading runs pop, four multiply steps and a two-step reciprocal divide
//  per channel, then output load; a point inside the set goes from pop
//  straight to output load. Shading overlaps the next point's iteration
//  through the job queue.
//  Reset is synchronous and clears only control state; no clearing pass.
//  A stalled output holds its beat while the engine keeps accepting points
//  until the queue fills.
//
module mandelbrot_escape_colorizer
    import mec_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mec_point_if.sink     i_point,
    mec_color_if.source   o_color
);

    localparam int CW = $clog2(MAX_ITER + 1);
    localparam int LW = $clog2(Q_DEPTH_DEF + 1);

    logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    logic [CW-1:0] q_push_count, q_pop_count;
    logic [LW-1:0] q_level;

    mec_iter #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point      (i_point),
        .o_push_valid (q_push_valid),
        .o_push_count (q_push_count),
        .i_push_ready (q_push_ready)
    );

    mec_fifo #(
        .W     (CW),
        .DEPTH (Q_DEPTH_DEF)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .i_push_data  (q_push_count),
        .o_push_ready (q_push_ready),
        .o_pop_valid  (q_pop_valid),
        .o_pop_data   (q_pop_count),
        .i_pop_ready  (q_pop_ready),
        .o_level      (q_level)
    );

    mec_shade #(
        .MAX_ITER (MAX_ITER)
    ) u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .i_pop_count (q_pop_count),
        .o_pop_ready (q_pop_ready),
        .o_color     (o_color)
    );

    // Queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= LW'(Q_DEPTH_DEF))
        else $error("job queue level above depth");

    // Engine holds one point at a time
    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_point.valid && i_point.ready) |=> !i_point.ready)
        else $error("point accepted while engine busy");

    // A push without a pop grows the queue by one
    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready))
        |=> (q_level == $past(q_level) + LW'(1)))
        else $error("job queue lost a push");

    // A count leaves the engine only within range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push_valid |-> (q_push_count <= CW'(MAX_ITER)))
        else $error("escape count beyond limit");

endmodule

[sim/mandelbrot_escape_colorizer_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// mandelbrot_escape_colorizer_test - self-checking bench for the colorizer
// Sends points c over the point channel and checks every color beat (escape
// count plus RGB) against hand-entered values or a bit-exact escape-time and shading
// predictor. A short table of hand-picked points comes first, then random
// points from the whole input range, from the region around the set, and its boundary.
// ============================================================================
module mandelbrot_escape_colorizer_test;
    import mec_pkg::*;

    localparam int ITER_MAX = MAX_ITER_DEF;
    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int RAND_PTS = 530;
    localparam int CALM_PTS = 80;    // tail of the run without idling

    // Shading gains: 255 times the polynomial weight; blue is doubled
    localparam int RED_GAIN = 2295;
    localparam int GRN_GAIN = 3825;
    localparam int BLU_GAIN = 4335;

    localparam logic [63:0]         Z_LIM     = 64'd1 << (FRAC + 1);
    localparam logic signed [127:0] ESC_RAD2  = 128'sd1 <<< (2 * FRAC + 2);
    localparam logic signed [127:0] Z_TOP     = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] Z_BOT     = -128'sh8000_0000_0000_0000;
    localparam logic [127:0]        ITER_POW4 = 128'(ITER_MAX) * ITER_MAX * ITER_MAX * ITER_MAX;

    // Q4.28 constants for stimulus
    localparam logic signed [31:0] Q_ONE  = 32'sh1000_0000;
    localparam logic signed [31:0] Q_TWO  = 32'sh2000_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_RIM  = 32'sh2800_0000;   // 2.5, always escapes
    localparam logic signed [31:0] Q_1P5  = 32'sh1800_0000;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] grn;
        logic [COL_W-1:0] blu;
    } color_t;

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic               known;
        color_t             want;
    } probe_t;

    logic i_clk;
    logic i_rst_n;

    mec_point_if pt ();
    mec_color_if col ();

    mandelbrot_escape_colorizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (pt),
        .o_color (col)
    );

    color_t pending_colors[$];
    probe_t probe_rows[$];
    int     mismatch_cnt = 0;
    bit     tx_idle      = 1'b1;
    bit     rx_idle      = 1'b1;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Q4.28 into the internal format: exact shift up, floor shift down
    function automatic logic signed [63:0] load_point(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        if (FRAC >= IN_FRAC)
            return w <<< (FRAC - IN_FRAC);
        return w >>> (IN_FRAC - FRAC);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
        if (v > Z_TOP)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (v < Z_BOT)
            return 64'sh8000_0000_0000_0000;
        return v[63:0];
    endfunction

    // z = z*z + c from z = 0, floor-rounded products, exact |z|^2 <= 4 test
    function automatic int escape_iters(input logic signed [31:0] cr, ci);
        logic signed [63:0]  zr, zi, c_r, c_i;
        logic signed [127:0] wr, wi, sq_r, sq_i;
        logic [63:0]         mr, mi;
        int                  n;
        c_r = load_point(cr);
        c_i = load_point(ci);
        zr  = '0;
        zi  = '0;
        n   = 0;
        while (n < ITER_MAX) begin
            mr = zr[63] ? -zr : zr;
            mi = zi[63] ? -zi : zi;
            if (mr > Z_LIM || mi > Z_LIM)
                break;
            wr   = zr;
            wi   = zi;
            sq_r = wr * wr;
            sq_i = wi * wi;
            if (sq_r + sq_i > ESC_RAD2)
                break;
            zr = clamp64(((sq_r - sq_i) >>> FRAC) + c_r);
            zi = clamp64(((2 * wr * wi) >>> FRAC) + c_i);
            n++;
        end
        return n;
    endfunction

    // floor(gain * (M-n)^pow_rest * n^(4-pow_rest) / (den * M^4))
    function automatic logic [COL_W-1:0] shade_channel(input int gain, den, pow_rest, n);
        logic [127:0] acc;
        int           k;
        acc = gain;
        for (k = 0; k < 4; k++)
            acc = acc * ((k < pow_rest) ? (ITER_MAX - n) : n);
        acc = acc / (128'(den) * ITER_POW4);
        return acc[COL_W-1:0];
    endfunction

    function automatic color_t predict_color(input logic signed [31:0] cr, ci);
        color_t c;
        int     n;
        n     = escape_iters(cr, ci);
        c.cnt = CNT_W'(n);
        if (n >= ITER_MAX) begin
            c.red = '0;
            c.grn = '0;
            c.blu = '0;
        end else begin
            c.red = shade_channel(RED_GAIN, 1, 1, n);
            c.grn = shade_channel(GRN_GAIN, 1, 2, n);
            c.blu = shade_channel(BLU_GAIN, 2, 3, n);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers and checker
    // ------------------------------------------------------------------------

    task automatic add_probe(input logic signed [31:0] cr, ci, input logic known,
                             input int cnt, red, grn, blu);
        probe_t p;
        p.cr       = cr;
        p.ci       = ci;
        p.known    = known;
        p.want.cnt = CNT_W'(cnt);
        p.want.red = COL_W'(red);
        p.want.grn = COL_W'(grn);
        p.want.blu = COL_W'(blu);
        probe_rows.push_back(p);
    endtask

    // One point beat; valid only moves at the falling edge
    task automatic send_point(input logic signed [31:0] cr, ci, input color_t want);
        @(negedge i_clk);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            pt.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        pt.valid  <= 1'b1;
        pt.c_real <= cr;
        pt.c_imag <= ci;
        do @(posedge i_clk); while (!pt.ready);
        pending_colors.push_back(want);
    endtask

    task automatic drain_colors();
        @(negedge i_clk);
        pt.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v, got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Color sink: ready drops at random while rx_idle is set
    initial begin
        int hold;
        hold      = 0;
        col.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                col.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                col.ready <= 1'b1;
            end
        end
    end

    // Compare each color beat with the oldest pending expectation
    always @(posedge i_clk) begin
        color_t want;
        if (i_rst_n && col.valid && col.ready) begin
            if (pending_colors.size() == 0) begin
                $error("color beat with no point pending: escape_count %0d",
                       col.escape_count);
                mismatch_cnt++;
            end else begin
                want = pending_colors.pop_front();
                check_field("escape_count", want.cnt, col.escape_count);
                check_field("red", want.red, col.red);
                check_field("green", want.grn, col.green);
                check_field("blue", want.blu, col.blue);
            end
        end
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic signed [31:0] cr, ci, in_r, in_i, out_r, out_i, mid_r, mid_i, span;
        color_t             want;
        int                 sel, k, t;

        pt.valid  = 1'b0;
        pt.c_real = '0;
        pt.c_imag = '0;
        i_rst_n   = 1'b0;

        //         c_real              c_imag             known cnt   r  g  b
        add_probe(32'sh0,             32'sh0,             1'b1, 1000, 0, 0, 0);
        add_probe(-Q_TWO,             32'sh0,             1'b1, 1000, 0, 0, 0); // sits on |z|=2
        add_probe(32'sh0,             Q_ONE,              1'b1, 1000, 0, 0, 0); // cycle through -i
        add_probe(-Q_ONE,             32'sh0,             1'b1, 1000, 0, 0, 0);
        add_probe(Q_MAX,              Q_MAX,              1'b1, 1,    0, 0, 2);
        add_probe(Q_MIN,              Q_MIN,              1'b1, 1,    0, 0, 2);
        add_probe(Q_MAX,              Q_MIN,              1'b1, 1,    0, 0, 2);
        add_probe(Q_MIN,              Q_MAX,              1'b1, 1,    0, 0, 2);
        add_probe(Q_TWO,              32'sh0,             1'b0, 0,    0, 0, 0);
        add_probe(32'sh0,             Q_TWO,              1'b0, 0,    0, 0, 0);
        add_probe(32'sh0,             -Q_TWO,             1'b0, 0,    0, 0, 0);
        add_probe(Q_TWO + 1,          32'sh0,             1'b0, 0,    0, 0, 0);
        add_probe(Q_TWO - 1,          32'sh0,             1'b0, 0,    0, 0, 0);
        add_probe(-Q_TWO - 1,         32'sh0,             1'b0, 0,    0, 0, 0);
        add_probe(Q_TWO,              Q_TWO,              1'b0, 0,    0, 0, 0);
        add_probe(32'sh0400_0000,     32'sh0,             1'b0, 0,    0, 0, 0); // cusp
        add_probe(32'sh0420_0000,     32'sh0,             1'b0, 0,    0, 0, 0); // just past cusp
        add_probe(32'shF400_0000,     32'sh0199_9999,     1'b0, 0,    0, 0, 0);
        add_probe(-32'sh1,            -32'sh1,            1'b0, 0,    0, 0, 0); // floor rounding
        add_probe(32'sh5555_5555,     32'sh2AAA_AAAA,     1'b0, 0,    0, 0, 0);
        add_probe(32'shAAAA_AAAA,     32'sh5555_5555,     1'b0, 0,    0, 0, 0);
        add_probe(32'shFE66_6666,     32'sh0A66_6666,     1'b0, 0,    0, 0, 0);
        add_probe(32'shE400_0000,     32'sh0,             1'b0, 0,    0, 0, 0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points
        foreach (probe_rows[k]) begin
            want = probe_rows[k].known ? probe_rows[k].want
                                       : predict_color(probe_rows[k].cr, probe_rows[k].ci);
            send_point(probe_rows[k].cr, probe_rows[k].ci, want);
        end
        drain_colors();

        // Random points
        for (k = 0; k < RAND_PTS; k++) begin
            if (k == RAND_PTS / 2)
                drain_colors();
            if (k == RAND_PTS - CALM_PTS) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                // anywhere in the input range
                cr = $urandom;
                ci = $urandom;
            end else if (sel < 60) begin
                // around the set, mostly points that escape
                for (t = 0; t < 2; t++) begin
                    cr = $urandom_range(0, 32'h3800_0000) - Q_RIM;
                    ci = $urandom_range(0, 32'h3000_0000) - Q_1P5;
                    if (escape_iters(cr, ci) < ITER_MAX)
                        break;
                end
            end else begin
                // bisect from the origin toward the 2.5 square for long escapes
                span = $urandom_range(0, 32'h5000_0000) - Q_RIM;
                case ($urandom_range(0, 3))
                    0:       begin out_r = Q_RIM;  out_i = span;   end
                    1:       begin out_r = -Q_RIM; out_i = span;   end
                    2:       begin out_r = span;   out_i = Q_RIM;  end
                    default: begin out_r = span;   out_i = -Q_RIM; end
                endcase
                in_r = '0;
                in_i = '0;
                repeat ($urandom_range(6, 14)) begin
                    mid_r = (in_r + out_r) >>> 1;
                    mid_i = (in_i + out_i) >>> 1;
                    if (escape_iters(mid_r, mid_i) >= ITER_MAX) begin
                        in_r = mid_r;
                        in_i = mid_i;
                    end else begin
                        out_r = mid_r;
                        out_i = mid_i;
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    cr = in_r;
                    ci = in_i;
                end else begin
                    cr = out_r;
                    ci = out_i;
                end
            end
            send_point(cr, ci, predict_color(cr, ci));
        end

        // Wind down
        drain_colors();
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/mec_pkg.sv
hdl/mec_ifs.sv
hdl/mec_iter.sv
hdl/mec_fifo.sv
hdl/mec_shade.sv
hdl/mandelbrot_escape_colorizer.sv
sim/mandelbrot_escape_colorizer_test.sv
